[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers, empty when synthesised
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CHK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
`define ASSERT_CHK_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CHK(lbl, clk, rstn, prop, msg)
`define ASSERT_CHK_NR(lbl, clk, prop, msg)
`endif

`endif

[rtl/ppc_pkg.sv]
// ----------------------------------------------------------------------------
// ppc_pkg
// shared constants for the planar pose composition pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ppc_pkg;

    localparam int POS_BITS_DEF    = 32;
    localparam int ANGLE_BITS_DEF  = 16;
    localparam int TRIG_STAGES_DEF = 16;

    localparam int ARC_LEN = 24;
    localparam int TURN_W  = 32;
    localparam int XY_W    = 34;
    localparam int Z_W     = 33;
    localparam int TRIG_W  = 16;

    localparam logic [31:0] GAIN_Q30 = 32'h26DD3B6A;

    // arctan(2^-i), 2^32 per turn
    localparam logic [31:0] ARC_TABLE [ARC_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic en;
        logic vld;
    } ppc_ctl_t;

endpackage

[rtl/planar_pose_compose.sv]
// throughput: one beat per cycle unless a result beat is held up; depth is set
// by the cordic stages plus the multiply, sum and output register stages
// a stall on the result side freezes the whole pipeline in place
// reset clears the valid bits and in-flight count; payload registers are not reset
// ----------------------------------------------------------------------------
// planar_pose_compose
// se(2) pose composition with heading jacobian terms, fully pipelined
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module planar_pose_compose
    import ppc_pkg::*;
#(
    parameter int POS_BITS    = POS_BITS_DEF,
    parameter int ANGLE_BITS  = ANGLE_BITS_DEF,
    parameter int TRIG_STAGES = TRIG_STAGES_DEF,
    localparam int S_W = ((4 * POS_BITS + 2 * ANGLE_BITS + 7) / 8) * 8,
    localparam int M_W = ((4 * POS_BITS + ANGLE_BITS + 2 * TRIG_W + 7) / 8) * 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    // base_x, base_y, base_heading, step_x, step_y, step_heading
    input  logic [S_W-1:0] s_axis_tdata,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    // out_x, out_y, out_heading, jac_x_heading, jac_y_heading, cos_heading,
    // sin_heading
    output logic [M_W-1:0] m_axis_tdata
);

    localparam int STAGES = (TRIG_STAGES > ARC_LEN) ? ARC_LEN : TRIG_STAGES;
    localparam int LAT    = STAGES + 5;
    localparam int SIDE_W = 4 * POS_BITS + ANGLE_BITS;
    localparam int CNT_W  = $clog2(LAT + 1) + 1;

    localparam int O_BY = POS_BITS;
    localparam int O_BH = 2 * POS_BITS;
    localparam int O_SX = 2 * POS_BITS + ANGLE_BITS;
    localparam int O_SY = 3 * POS_BITS + ANGLE_BITS;
    localparam int O_SH = 4 * POS_BITS + ANGLE_BITS;

    ppc_ctl_t ctl_cordic, ctl_rot;

    logic signed [POS_BITS-1:0] base_x, base_y, step_x, step_y;
    logic [ANGLE_BITS-1:0]      base_heading, step_heading, heading_sum;
    logic [SIDE_W-1:0]          side_in, side_out;

    logic                     cordic_vld;
    logic signed [TRIG_W-1:0] cordic_cos, cordic_sin;

    logic                       res_vld;
    logic signed [POS_BITS-1:0] out_x, out_y, jac_x_heading, jac_y_heading;
    logic [ANGLE_BITS-1:0]      out_heading;
    logic signed [TRIG_W-1:0]   cos_heading, sin_heading;

    logic             pipe_en;
    logic [CNT_W-1:0] inflight_reg, inflight_next;

    assign base_x       = s_axis_tdata[POS_BITS-1:0];
    assign base_y       = s_axis_tdata[O_BY +: POS_BITS];
    assign base_heading = s_axis_tdata[O_BH +: ANGLE_BITS];
    assign step_x       = s_axis_tdata[O_SX +: POS_BITS];
    assign step_y       = s_axis_tdata[O_SY +: POS_BITS];
    assign step_heading = s_axis_tdata[O_SH +: ANGLE_BITS];

    assign heading_sum = base_heading + step_heading;
    assign side_in     = {heading_sum, base_y, base_x, step_y, step_x};

    // the whole pipe moves unless a result beat is held up
    assign pipe_en       = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = pipe_en;

    assign ctl_cordic = '{en: pipe_en, vld: s_axis_tvalid};
    assign ctl_rot    = '{en: pipe_en, vld: cordic_vld};

    ppc_cordic #(
        .ANGLE_BITS (ANGLE_BITS),
        .STAGES     (STAGES),
        .SIDE_W     (SIDE_W)
    ) u_cordic (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl_in   (ctl_cordic),
        .heading  (base_heading),
        .side_in  (side_in),
        .vld_out  (cordic_vld),
        .cos_out  (cordic_cos),
        .sin_out  (cordic_sin),
        .side_out (side_out)
    );

    ppc_rotate #(
        .POS_BITS   (POS_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_rotate (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctl_in        (ctl_rot),
        .cos_in        (cordic_cos),
        .sin_in        (cordic_sin),
        .step_x        (side_out[POS_BITS-1:0]),
        .step_y        (side_out[POS_BITS +: POS_BITS]),
        .base_x        (side_out[2*POS_BITS +: POS_BITS]),
        .base_y        (side_out[3*POS_BITS +: POS_BITS]),
        .heading_in    (side_out[4*POS_BITS +: ANGLE_BITS]),
        .vld_out       (res_vld),
        .out_x         (out_x),
        .out_y         (out_y),
        .out_heading   (out_heading),
        .jac_x_heading (jac_x_heading),
        .jac_y_heading (jac_y_heading),
        .cos_heading   (cos_heading),
        .sin_heading   (sin_heading)
    );

    assign m_axis_tvalid = res_vld;
    assign m_axis_tdata  = M_W'({sin_heading, cos_heading, jac_y_heading, jac_x_heading,
                                 out_heading, out_y, out_x});

    // beats inside the pipe
    always_comb begin
        inflight_next = inflight_reg;
        if (s_axis_tvalid && s_axis_tready) begin
            inflight_next = inflight_next + CNT_W'(1);
        end
        if (m_axis_tvalid && m_axis_tready) begin
            inflight_next = inflight_next - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    `ASSERT_CHK(a_inflight_bound, aclk, aresetn, inflight_reg <= CNT_W'(LAT), "too many beats in flight")
    `ASSERT_CHK(a_stall_blocks_input, aclk, aresetn, (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready, "input taken while result stalled")
    `ASSERT_CHK(a_out_needs_inflight, aclk, aresetn, m_axis_tvalid |-> (inflight_reg != '0), "result beat with empty pipe")
    `ASSERT_CHK_NR(a_reset_clears_out, aclk, !aresetn |=> !m_axis_tvalid, "result valid after reset")

endmodule

[rtl/ppc_cordic.sv]
// ----------------------------------------------------------------------------
// ppc_cordic
// pipelined rotation-mode cordic giving q1.15 cosine and sine of a binary
// angle, one stage per micro-rotation, with a side payload kept in step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppc_cordic
    import ppc_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int STAGES     = TRIG_STAGES_DEF,
    parameter int SIDE_W     = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  ppc_ctl_t                 ctl_in,
    input  logic [ANGLE_BITS-1:0]    heading,
    input  logic [SIDE_W-1:0]        side_in,
    output logic                     vld_out,
    output logic signed [TRIG_W-1:0] cos_out,
    output logic signed [TRIG_W-1:0] sin_out,
    output logic [SIDE_W-1:0]        side_out
);

    localparam logic signed [XY_W-1:0] HALF_LSB = XY_W'(16384);

    logic                   vld_reg  [STAGES+2];
    logic [SIDE_W-1:0]      side_reg [STAGES+2];
    logic                   flip_reg [STAGES+1];
    logic signed [XY_W-1:0] x_reg    [STAGES+1];
    logic signed [XY_W-1:0] y_reg    [STAGES+1];
    logic signed [Z_W-1:0]  z_reg    [STAGES+1];
    logic signed [TRIG_W-1:0] cos_reg, sin_reg;

    logic [TURN_W-1:0] turn;
    logic              flip_next;
    logic [TURN_W-1:0] turn_f;

    function automatic logic signed [TRIG_W-1:0] sat16(input logic signed [XY_W-1:0] v);
        logic signed [XY_W-1:0] sh;
        logic signed [TRIG_W-1:0] r;
        sh = (v + HALF_LSB) >>> 15;
        if (&sh[XY_W-1:TRIG_W-1] || ~|sh[XY_W-1:TRIG_W-1]) begin
            r = sh[TRIG_W-1:0];
        end else if (sh[XY_W-1]) begin
            r = {1'b1, {(TRIG_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(TRIG_W-1){1'b1}}};
        end
        return r;
    endfunction

    // fold second and third quadrants by half a turn
    assign turn      = {heading, {(TURN_W-ANGLE_BITS){1'b0}}};
    assign flip_next = turn[TURN_W-1] ^ turn[TURN_W-2];
    assign turn_f    = turn ^ {flip_next, {(TURN_W-1){1'b0}}};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (ctl_in.en) begin
            vld_reg[0] <= ctl_in.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl_in.en) begin
            side_reg[0] <= side_in;
            flip_reg[0] <= flip_next;
            x_reg[0]    <= $signed({{(XY_W-32){1'b0}}, GAIN_Q30});
            y_reg[0]    <= '0;
            z_reg[0]    <= $signed({turn_f[TURN_W-1], turn_f});
        end
    end

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic signed [XY_W-1:0] xs, ys, x_next, y_next;
        logic signed [Z_W-1:0]  arc, z_next;

        assign xs  = x_reg[k] >>> k;
        assign ys  = y_reg[k] >>> k;
        assign arc = $signed({1'b0, ARC_TABLE[k]});

        always_comb begin
            if (!z_reg[k][Z_W-1]) begin
                x_next = x_reg[k] - ys;
                y_next = y_reg[k] + xs;
                z_next = z_reg[k] - arc;
            end else begin
                x_next = x_reg[k] + ys;
                y_next = y_reg[k] - xs;
                z_next = z_reg[k] + arc;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (ctl_in.en) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (ctl_in.en) begin
                side_reg[k+1] <= side_reg[k];
                flip_reg[k+1] <= flip_reg[k];
                x_reg[k+1]    <= x_next;
                y_reg[k+1]    <= y_next;
                z_reg[k+1]    <= z_next;
            end
        end
    end

    logic signed [XY_W-1:0] xf, yf;
    assign xf = flip_reg[STAGES] ? -x_reg[STAGES] : x_reg[STAGES];
    assign yf = flip_reg[STAGES] ? -y_reg[STAGES] : y_reg[STAGES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[STAGES+1] <= 1'b0;
        end else if (ctl_in.en) begin
            vld_reg[STAGES+1] <= vld_reg[STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl_in.en) begin
            side_reg[STAGES+1] <= side_reg[STAGES];
            cos_reg            <= sat16(xf);
            sin_reg            <= sat16(yf);
        end
    end

    assign vld_out  = vld_reg[STAGES+1];
    assign side_out = side_reg[STAGES+1];
    assign cos_out  = cos_reg;
    assign sin_out  = sin_reg;

endmodule

[rtl/ppc_rotate.sv]
// ----------------------------------------------------------------------------
// ppc_rotate
// rotates the step by the base heading, rounds, translates and saturates;
// multiply, sum and output register stages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppc_rotate
    import ppc_pkg::*;
#(
    parameter int POS_BITS   = POS_BITS_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  ppc_ctl_t                   ctl_in,
    input  logic signed [TRIG_W-1:0]   cos_in,
    input  logic signed [TRIG_W-1:0]   sin_in,
    input  logic signed [POS_BITS-1:0] base_x,
    input  logic signed [POS_BITS-1:0] base_y,
    input  logic signed [POS_BITS-1:0] step_x,
    input  logic signed [POS_BITS-1:0] step_y,
    input  logic [ANGLE_BITS-1:0]      heading_in,
    output logic                       vld_out,
    output logic signed [POS_BITS-1:0] out_x,
    output logic signed [POS_BITS-1:0] out_y,
    output logic [ANGLE_BITS-1:0]      out_heading,
    output logic signed [POS_BITS-1:0] jac_x_heading,
    output logic signed [POS_BITS-1:0] jac_y_heading,
    output logic signed [TRIG_W-1:0]   cos_heading,
    output logic signed [TRIG_W-1:0]   sin_heading
);

    localparam int PW = POS_BITS + TRIG_W;
    localparam int SW = PW + 1;
    localparam int RW = POS_BITS + 2;
    localparam int OW = POS_BITS + 3;
    localparam logic signed [SW-1:0] HALF_LSB = SW'(16384);

    // stage 1: products
    logic                       vld1_reg;
    logic signed [PW-1:0]       pxc_reg, pys_reg, pxs_reg, pyc_reg;
    logic signed [POS_BITS-1:0] bx1_reg, by1_reg;
    logic [ANGLE_BITS-1:0]      hd1_reg;
    logic signed [TRIG_W-1:0]   c1_reg, s1_reg;

    // stage 2: rounded rotated step
    logic                       vld2_reg;
    logic signed [RW-1:0]       rx_reg, ry_reg;
    logic signed [POS_BITS-1:0] bx2_reg, by2_reg;
    logic [ANGLE_BITS-1:0]      hd2_reg;
    logic signed [TRIG_W-1:0]   c2_reg, s2_reg;

    // stage 3: output register
    logic                       vld3_reg;
    logic signed [POS_BITS-1:0] ox_reg, oy_reg, jx_reg, jy_reg;
    logic [ANGLE_BITS-1:0]      hd3_reg;
    logic signed [TRIG_W-1:0]   c3_reg, s3_reg;

    logic signed [PW-1:0] sx_w, sy_w, c_w, s_w;
    logic signed [SW-1:0] sum_x, sum_y, shx, shy;
    logic signed [OW-1:0] ox_next, oy_next, jx_next, jy_next;

    function automatic logic signed [POS_BITS-1:0] sat(input logic signed [OW-1:0] v);
        logic signed [POS_BITS-1:0] r;
        if (&v[OW-1:POS_BITS-1] || ~|v[OW-1:POS_BITS-1]) begin
            r = v[POS_BITS-1:0];
        end else if (v[OW-1]) begin
            r = {1'b1, {(POS_BITS-1){1'b0}}};
        end else begin
            r = {1'b0, {(POS_BITS-1){1'b1}}};
        end
        return r;
    endfunction

    assign sx_w = $signed({{TRIG_W{step_x[POS_BITS-1]}}, step_x});
    assign sy_w = $signed({{TRIG_W{step_y[POS_BITS-1]}}, step_y});
    assign c_w  = $signed({{POS_BITS{cos_in[TRIG_W-1]}}, cos_in});
    assign s_w  = $signed({{POS_BITS{sin_in[TRIG_W-1]}}, sin_in});

    assign sum_x = $signed({pxc_reg[PW-1], pxc_reg}) - $signed({pys_reg[PW-1], pys_reg})
                   + HALF_LSB;
    assign sum_y = $signed({pxs_reg[PW-1], pxs_reg}) + $signed({pyc_reg[PW-1], pyc_reg})
                   + HALF_LSB;
    assign shx   = sum_x >>> 15;
    assign shy   = sum_y >>> 15;

    assign ox_next = $signed({{3{bx2_reg[POS_BITS-1]}}, bx2_reg})
                     + $signed({rx_reg[RW-1], rx_reg});
    assign oy_next = $signed({{3{by2_reg[POS_BITS-1]}}, by2_reg})
                     + $signed({ry_reg[RW-1], ry_reg});
    assign jx_next = -$signed({ry_reg[RW-1], ry_reg});
    assign jy_next = $signed({rx_reg[RW-1], rx_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end else if (ctl_in.en) begin
            vld1_reg <= ctl_in.vld;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl_in.en) begin
            pxc_reg <= sx_w * c_w;
            pys_reg <= sy_w * s_w;
            pxs_reg <= sx_w * s_w;
            pyc_reg <= sy_w * c_w;
            bx1_reg <= base_x;
            by1_reg <= base_y;
            hd1_reg <= heading_in;
            c1_reg  <= cos_in;
            s1_reg  <= sin_in;

            rx_reg  <= shx[RW-1:0];
            ry_reg  <= shy[RW-1:0];
            bx2_reg <= bx1_reg;
            by2_reg <= by1_reg;
            hd2_reg <= hd1_reg;
            c2_reg  <= c1_reg;
            s2_reg  <= s1_reg;

            ox_reg  <= sat(ox_next);
            oy_reg  <= sat(oy_next);
            jx_reg  <= sat(jx_next);
            jy_reg  <= sat(jy_next);
            hd3_reg <= hd2_reg;
            c3_reg  <= c2_reg;
            s3_reg  <= s2_reg;
        end
    end

    assign vld_out       = vld3_reg;
    assign out_x         = ox_reg;
    assign out_y         = oy_reg;
    assign out_heading   = hd3_reg;
    assign jac_x_heading = jx_reg;
    assign jac_y_heading = jy_reg;
    assign cos_heading   = c3_reg;
    assign sin_heading   = s3_reg;

endmodule
